// ===== rtl/ppa_pkg.sv =====
// Shared types and constants for the path particle advance block.
package ppa_pkg;
  localparam int SEG_AW   = 16;
  localparam int NODE_AW  = 16;
  localparam int MAX_HOPS = 1024;
  localparam int HOP_W    = $clog2(MAX_HOPS + 1);
  localparam int REM_W    = 48;
  localparam int POS_W    = 17;
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(65536);

  localparam logic [1:0] REQ_SEG  = 2'd0;
  localparam logic [1:0] REQ_NODE = 2'd1;
  localparam logic [1:0] REQ_ADV  = 2'd2;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_ZERO  = 2'd1;
  localparam logic [1:0] FAULT_HOPS  = 2'd2;

  typedef struct packed {
    logic              has_next;
    logic [SEG_AW-1:0] next_seg;
    logic [NODE_AW-1:0] start_node;
    logic [NODE_AW-1:0] end_node;
    logic              outlet;
    logic [31:0]       seg_time;
  } seg_ent_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } node_ent_t;
endpackage

// ===== rtl/path_particle_advance.sv =====
// Top level of the path particle advance block: control sequencer and datapath.
//
// Usage: one valid/ready input channel carries write beats and advance beats.
// A segment write (req_type 0) or node write (req_type 1) stores one table
// entry and gives no result. An advance beat (req_type 2) walks the chained
// segments held in the segment table, then gives one result beat on the
// out_ channel.
// Each hop costs one segment table read, one registered multiply for the
// segment cost and one compare; the final fraction comes from a bit-serial
// 48-bit divider; coordinates take two node reads and one multiply per axis.
// One advance is worked at a time; in_ready is low while it runs.
// The result sits in an output register, so a new beat is accepted while
// a result waits; a finished advance holds until the register frees.
// Reset clears control state only; table contents stay undefined until
// software writes them, and no clearing pass runs.
module path_particle_advance
  import ppa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [15:0]        in_index,
  input  logic               in_has_next,
  input  logic [15:0]        in_next_segment,
  input  logic [15:0]        in_start_node,
  input  logic [15:0]        in_end_node,
  input  logic [31:0]        in_seg_time,
  input  logic               in_ends_at_outlet,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic [31:0]        in_time_budget,
  input  logic [16:0]        in_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_segment_now,
  output logic [16:0]        out_new_position,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic               out_stopped,
  output logic               out_entered_outlet,
  output logic [1:0]         out_fault
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOOK = 9'b000000010,
    S_CMP  = 9'b000000100,
    S_FIN  = 9'b000001000,
    S_DIVW = 9'b000010000,
    S_NA   = 9'b000100000,
    S_NB   = 9'b001000000,
    S_NC   = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // walk registers
  logic [SEG_AW-1:0] seg_r, seg_nxt;
  logic [REM_W-1:0]  remain_r, remain_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [HOP_W-1:0]  hops_r, hops_nxt;
  logic              stop_r, stop_nxt, outlet_r, outlet_nxt, hopped_r, hopped_nxt;
  logic [1:0]        fault_r, fault_nxt;
  logic [REM_W-1:0]  cost_r;
  node_ent_t         na_r;
  logic signed [49:0] px_r, py_r;

  // output register
  logic               ov_r, ov_nxt;
  logic [15:0]        o_seg_r;
  logic [16:0]        o_pos_r;
  logic signed [31:0] o_x_r, o_y_r;
  logic               o_stop_r, o_outlet_r;
  logic [1:0]         o_fault_r;

  seg_ent_t  seg_wdata, seg_rd;
  node_ent_t node_wdata, node_rd;
  logic      seg_we, node_we;
  logic [NODE_AW-1:0] node_raddr;
  logic      div_start, div_done;
  logic [REM_W-1:0] div_q;
  logic      accept, out_free;
  logic [POS_W-1:0] pos_room;
  logic signed [32:0] dx, dy;
  logic signed [31:0] res_x, res_y;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !ov_r || out_ready;

  assign seg_we    = accept && (in_req_type == REQ_SEG);
  assign node_we   = accept && (in_req_type == REQ_NODE);
  assign seg_wdata = '{has_next: in_has_next, next_seg: in_next_segment,
                       start_node: in_start_node, end_node: in_end_node,
                       outlet: in_ends_at_outlet, seg_time: in_seg_time};
  assign node_wdata = '{x: in_coord_x, y: in_coord_y};

  // read address follows the next segment so read data tracks seg_r
  ppa_seg_mem u_seg_mem (
    .clk   (clk),
    .we    (seg_we),
    .waddr (in_index),
    .wdata (seg_wdata),
    .raddr (seg_nxt),
    .rdata (seg_rd)
  );

  assign node_raddr = (state_r == S_NA) ? seg_rd.start_node : seg_rd.end_node;

  ppa_node_mem u_node_mem (
    .clk   (clk),
    .we    (node_we),
    .waddr (in_index),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rd)
  );

  assign div_start = (state_r == S_FIN) && (remain_r != '0) && (seg_rd.seg_time != '0);

  ppa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (remain_r),
    .divisor  (seg_rd.seg_time),
    .done     (div_done),
    .quotient (div_q)
  );

  assign pos_room = POS_ONE - pos_r;

  always_comb begin
    state_nxt  = state_r;
    seg_nxt    = seg_r;
    remain_nxt = remain_r;
    pos_nxt    = pos_r;
    hops_nxt   = hops_r;
    stop_nxt   = stop_r;
    outlet_nxt = outlet_r;
    hopped_nxt = hopped_r;
    fault_nxt  = fault_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_req_type == REQ_ADV)) begin
          seg_nxt    = in_index;
          remain_nxt = {in_time_budget, 16'h0000};
          pos_nxt    = (in_position > POS_ONE) ? POS_ONE : in_position;
          hops_nxt   = '0;
          stop_nxt   = 1'b0;
          outlet_nxt = 1'b0;
          hopped_nxt = 1'b0;
          fault_nxt  = FAULT_NONE;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (hopped_r && seg_rd.outlet) begin
          outlet_nxt = 1'b1;
        end
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (remain_r < cost_r) begin
          state_nxt = S_FIN;
        end else if (!seg_rd.has_next) begin
          remain_nxt = '0;
          pos_nxt    = POS_ONE;
          stop_nxt   = 1'b1;
          state_nxt  = S_FIN;
        end else if (hops_r >= HOP_W'(MAX_HOPS)) begin
          fault_nxt = FAULT_HOPS;
          state_nxt = S_FIN;
        end else begin
          remain_nxt = remain_r - cost_r;
          pos_nxt    = '0;
          seg_nxt    = seg_rd.next_seg;
          hops_nxt   = hops_r + 1'b1;
          hopped_nxt = 1'b1;
          state_nxt  = S_LOOK;
        end
      end
      S_FIN: begin
        if (remain_r == '0) begin
          state_nxt = S_NA;
        end else if (seg_rd.seg_time == '0) begin
          fault_nxt = FAULT_ZERO;
          state_nxt = S_NA;
        end else begin
          state_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          if (div_q >= REM_W'(pos_room)) begin
            pos_nxt = POS_ONE;
          end else begin
            pos_nxt = pos_r + div_q[POS_W-1:0];
          end
          state_nxt = S_NA;
        end
      end
      S_NA: state_nxt = S_NB;
      S_NB: state_nxt = S_NC;
      S_NC: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ov_nxt = ((state_r == S_OUT) && out_free) ? 1'b1 :
                  (out_ready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // node deltas; arithmetic shift of the product is the floor
  assign dx    = 33'(node_rd.x) - 33'(na_r.x);
  assign dy    = 33'(node_rd.y) - 33'(na_r.y);
  assign res_x = na_r.x + 32'(px_r >>> 16);
  assign res_y = na_r.y + 32'(py_r >>> 16);

  always_ff @(posedge clk) begin
    seg_r    <= seg_nxt;
    remain_r <= remain_nxt;
    pos_r    <= pos_nxt;
    hops_r   <= hops_nxt;
    stop_r   <= stop_nxt;
    outlet_r <= outlet_nxt;
    hopped_r <= hopped_nxt;
    fault_r  <= fault_nxt;
    // segment cost of the rest of this segment, exact in Q32.16
    cost_r   <= REM_W'(seg_rd.seg_time) * REM_W'(POS_ONE - pos_r);
    if (state_r == S_NB) begin
      na_r <= node_rd;
    end
    if (state_r == S_NC) begin
      px_r <= 50'(dx) * 50'($signed({1'b0, pos_r}));
      py_r <= 50'(dy) * 50'($signed({1'b0, pos_r}));
    end
    if ((state_r == S_OUT) && out_free) begin
      o_seg_r    <= seg_r;
      o_pos_r    <= pos_r;
      o_x_r      <= res_x;
      o_y_r      <= res_y;
      o_stop_r   <= stop_r;
      o_outlet_r <= outlet_r;
      o_fault_r  <= fault_r;
    end
  end

  assign out_valid          = ov_r;
  assign out_segment_now    = o_seg_r;
  assign out_new_position   = o_pos_r;
  assign out_pos_x          = o_x_r;
  assign out_pos_y          = o_y_r;
  assign out_stopped        = o_stop_r;
  assign out_entered_outlet = o_outlet_r;
  assign out_fault          = o_fault_r;
endmodule

// ===== rtl/ppa_seg_mem.sv =====
// Segment table: one write port, one registered read port.
module ppa_seg_mem
  import ppa_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [SEG_AW-1:0] waddr,
  input  seg_ent_t          wdata,
  input  logic [SEG_AW-1:0] raddr,
  output seg_ent_t          rdata
);
  seg_ent_t mem [2**SEG_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/ppa_node_mem.sv =====
// Node coordinate table: one write port, one registered read port.
module ppa_node_mem
  import ppa_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [NODE_AW-1:0] waddr,
  input  node_ent_t          wdata,
  input  logic [NODE_AW-1:0] raddr,
  output node_ent_t          rdata
);
  node_ent_t mem [2**NODE_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/ppa_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ppa_div
  import ppa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [REM_W-1:0] dividend,
  input  logic [31:0]      divisor,
  output logic             done,
  output logic [REM_W-1:0] quotient
);
  localparam int CNT_W = $clog2(REM_W + 1);

  logic [REM_W-1:0] quo_r, quo_nxt;
  logic [32:0]      rem_r, rem_nxt;
  logic [31:0]      dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0]      trial;
  logic [33:0]      diff;

  always_comb begin
    trial    = {rem_r[31:0], quo_r[REM_W-1]};
    diff     = {1'b0, trial} - {2'b00, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(REM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[33]) begin
        rem_nxt = diff[32:0];
        quo_nxt = {quo_r[REM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[REM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
